// ===== sv/spd_pkg.sv =====
// Shared types and constants for the stuffed packet deframer.
package spd_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam logic [7:0] MAX_PAYLOAD = 8'd60;

	localparam logic [7:0] ESC_BYTE = 8'h96;
	localparam logic [7:0] CODE_SOF = 8'd1;
	localparam logic [7:0] CODE_EOF = 8'd2;
	localparam logic [7:0] ESC_PAR  = 8'd3;
	localparam logic [7:0] CODE_LIT = 8'd4;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_LEN   = 3'd1,
		ST_CSUM  = 3'd2,
		ST_PAR   = 3'd3,
		ST_UNDEF = 3'd4,
		ST_FULL  = 3'd5
	} status_t;

	// what one received byte asks of the output side
	typedef struct packed {
		logic        res;     // one immediate result beat
		logic        run;     // start a payload readout
		status_t     status;
		logic [15:0] addr;
		logic [5:0]  len;
	} ev_t;

endpackage

// ===== sv/stuffed_packet_deframer.sv =====
// Top level of the byte-stuffed packet deframer with xor checksum.
//
// Input channel: one raw link byte (rx_byte) per beat, in_valid/in_ready.
// Output channel: one result per beat, out_valid/out_ready, carrying status,
// data_valid, data_byte, packet_address, payload_length and last.
// Escape 0x96 followed by 1/2/3/4 means start, stop, parity, literal 0x96.
// Bytes between start and stop are written to an on-chip frame store.
// On stop the frame is checked with a running xor and the last three stored
// bytes (address low, address high, checksum), so no scan is needed.
// Throughput: one input byte per cycle while no readout runs. A byte that
// gives an error (or an empty good packet) is taken once the result register
// is free or emptying that cycle. A good packet of L payload bytes is read
// out of the store one byte per cycle while the receiver keeps up, through
// the single registered read port; the input is held off until readout ends.
// An immediate result appears the cycle after its byte; payload beats follow
// a stop through the store read register and the result register.
// Reset clears the escape history, frame flag, fill count and all handshake
// state; store contents are not cleared and never read before written.
// A stalled receiver holds the result register; readout pauses, no data lost.
module stuffed_packet_deframer #(
	parameter int STORE_DEPTH = spd_pkg::STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic [15:0] packet_address,
	output logic [5:0]  payload_length,
	output logic        last
);
	import spd_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int FW = $clog2(STORE_DEPTH + 1);

	ev_t           ev;
	logic          take;
	logic          busy, out_free;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	// bytes with no immediate result need only an idle sequencer
	assign in_ready = !busy && (out_free || !ev.res);
	assign take     = in_valid && in_ready;

	spd_rx #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW),
		.FW    (FW)
	) u_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.ev      (ev)
	);

	spd_mem #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	spd_out #(
		.AW (AW)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.ev             (ev),
		.rd_data        (rd_data),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.busy           (busy),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.data_valid     (data_valid),
		.data_byte      (data_byte),
		.packet_address (packet_address),
		.payload_length (payload_length),
		.last           (last)
	);

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store written during readout");

	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("input ready while reading out");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd5)
		else $error("status code out of range");

endmodule

// ===== sv/spd_mem.sv =====
// Frame store: one write port, one registered read port.
module spd_mem #(
	parameter int DEPTH = spd_pkg::STORE_DEPTH_DEF,
	parameter int AW    = $clog2(spd_pkg::STORE_DEPTH_DEF)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/spd_rx.sv =====
// Receive side: escape decode, frame tracking, running checksum and frame check.
module spd_rx #(
	parameter int DEPTH = spd_pkg::STORE_DEPTH_DEF,
	parameter int AW    = $clog2(spd_pkg::STORE_DEPTH_DEF),
	parameter int FW    = $clog2(spd_pkg::STORE_DEPTH_DEF + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    rx_byte,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output spd_pkg::ev_t  ev
);
	import spd_pkg::*;

	logic [7:0]    prev_q;
	logic          in_frame_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    len_q;
	logic [7:0]    acc_q;
	logic [7:0]    tap1_q, tap2_q, tap3_q;

	logic       esc, is_start, is_stop, is_par, is_undef, is_data;
	logic       store, full;
	logic [7:0] dbyte;
	logic [8:0] n9, lenp4;

	always_comb begin
		esc      = (prev_q == ESC_BYTE);
		is_start = esc && (rx_byte == CODE_SOF);
		is_stop  = esc && (rx_byte == CODE_EOF);
		is_par   = esc && (rx_byte == ESC_PAR);
		is_undef = esc && (rx_byte != CODE_SOF) && (rx_byte != CODE_EOF)
			&& (rx_byte != ESC_PAR) && (rx_byte != CODE_LIT);
		is_data  = esc ? (rx_byte == CODE_LIT) : (rx_byte != ESC_BYTE);
		dbyte    = esc ? ESC_BYTE : rx_byte;
		store    = is_data && in_frame_q && (fill_q < FW'(DEPTH));
		full     = is_data && in_frame_q && (fill_q >= FW'(DEPTH));
		n9       = 9'(fill_q);
		lenp4    = {1'b0, len_q} + 9'd4;
	end

	assign wr_en   = take && store;
	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = dbyte;

	always_comb begin
		ev = '0;
		if (is_undef) begin
			ev.res    = 1'b1;
			ev.status = ST_UNDEF;
		end else if (is_par) begin
			ev.res    = 1'b1;
			ev.status = ST_PAR;
		end else if (full) begin
			ev.res    = 1'b1;
			ev.status = ST_FULL;
		end else if (is_stop && in_frame_q) begin
			if (fill_q == '0 || len_q > MAX_PAYLOAD || n9 != lenp4) begin
				ev.res    = 1'b1;
				ev.status = ST_LEN;
			end else if (acc_q != 8'd0) begin
				// xor over payload, address and checksum must cancel
				ev.res    = 1'b1;
				ev.status = ST_CSUM;
			end else if (len_q == 8'd0) begin
				ev.res  = 1'b1;
				ev.addr = {tap2_q, tap3_q};
			end else begin
				ev.run  = 1'b1;
				ev.addr = {tap2_q, tap3_q};
				ev.len  = len_q[5:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			in_frame_q <= 1'b0;
			fill_q     <= '0;
		end else if (take) begin
			prev_q <= rx_byte;
			if (is_start) begin
				in_frame_q <= 1'b1;
				fill_q     <= '0;
			end else if (is_stop) begin
				in_frame_q <= 1'b0;
			end else if (store) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	// length byte, running xor and the last three stored bytes
	always_ff @(posedge clk) begin
		if (take && store) begin
			if (fill_q == '0) begin
				len_q <= dbyte;
				acc_q <= 8'd0;
			end else begin
				acc_q <= acc_q ^ dbyte;
			end
			tap1_q <= dbyte;
			tap2_q <= tap1_q;
			tap3_q <= tap2_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count beyond store depth");

endmodule

// ===== sv/spd_out.sv =====
// Output side: payload readout sequencer and the result register.
module spd_out #(
	parameter int AW = $clog2(spd_pkg::STORE_DEPTH_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  spd_pkg::ev_t  ev,
	input  logic [7:0]    rd_data,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	output logic          busy,
	output logic          out_free,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic          data_valid,
	output logic [7:0]    data_byte,
	output logic [15:0]   packet_address,
	output logic [5:0]    payload_length,
	output logic          last
);
	import spd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t        state_q;
	logic [AW-1:0] rd_ptr_q;
	logic [5:0]    rd_left_q;
	logic          pend_q;
	logic          last_s1;
	logic [15:0]   pkt_addr_q;
	logic [5:0]    pkt_len_q;

	logic          out_valid_q;
	status_t       status_q;
	logic          dv_q;
	logic [7:0]    byte_q;
	logic [15:0]   addr_q;
	logic [5:0]    len_q;
	logic          last_q;

	logic out_load, imm_load;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		out_load = pend_q && out_free;
		imm_load = take && ev.res;
		rd_en    = (state_q == S_READ) && (rd_left_q != 6'd0) && (!pend_q || out_load);
		busy     = (state_q != S_IDLE);
	end

	assign rd_addr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_left_q   <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take && ev.run) begin
						state_q   <= S_READ;
						rd_left_q <= ev.len;
					end
				end
				S_READ: begin
					if (rd_en) begin
						rd_left_q <= rd_left_q - 6'd1;
					end else if (rd_left_q == 6'd0 && !pend_q) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (rd_en) begin
				pend_q <= 1'b1;
			end else if (out_load) begin
				pend_q <= 1'b0;
			end

			if (out_load || imm_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ev.run) begin
			rd_ptr_q   <= AW'(1);   // entry 0 is the length byte
			pkt_addr_q <= ev.addr;
			pkt_len_q  <= ev.len;
		end else if (rd_en) begin
			rd_ptr_q <= rd_ptr_q + AW'(1);
		end
		if (rd_en) begin
			last_s1 <= (rd_left_q == 6'd1);
		end
		if (out_load) begin
			status_q <= ST_OK;
			dv_q     <= 1'b1;
			byte_q   <= rd_data;
			addr_q   <= pkt_addr_q;
			len_q    <= pkt_len_q;
			last_q   <= last_s1;
		end else if (imm_load) begin
			status_q <= ev.status;
			dv_q     <= 1'b0;
			byte_q   <= 8'd0;
			addr_q   <= ev.addr;
			len_q    <= ev.len;
			last_q   <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign data_valid     = dv_q;
	assign data_byte      = byte_q;
	assign packet_address = addr_q;
	assign payload_length = len_q;
	assign last           = last_q;

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (state_q == S_IDLE) && !pend_q)
		else $error("byte taken during readout");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		take && ev.run |-> ev.len != 6'd0)
		else $error("readout started with empty payload");

	a_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_load && imm_load))
		else $error("two sources load the result register");

	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_s1 |-> rd_left_q == 6'd0)
		else $error("final payload beat with reads outstanding");

endmodule
